@@ rtl/core/qscsc_pkg.sv @@
// Package of types and constants for the card batch sorter.
package qscsc_pkg;
   localparam int CAPACITY = 64;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [7:0] suit;
      logic [29:0] card_value;
      logic last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_suit;
      logic [29:0] out_value;
      logic is_stable;
      logic overflowed;
      logic end_of_batch;
   } rsp_type;

   typedef struct packed {
      logic [7:0] suit;
      logic [29:0] key;
   } card_type;

   typedef enum logic [7:0] {
      OP_IDLE  = 8'b0000_0001,
      OP_QSORT = 8'b0000_0010,
      OP_MSORT = 8'b0000_0100,
      OP_CMP   = 8'b0000_1000,
      OP_EMIT  = 8'b0001_0000,
      OP_LOAD  = 8'b0010_0000
   } op_type;

   typedef struct packed {
      logic start_q;
      logic start_m;
      logic start_c;
      logic start_e;
   } cmd_type;

   typedef struct packed {
      logic done_q;
      logic done_m;
      logic done_c;
      logic done_e;
   } sts_type;
endpackage

@@ rtl/core/qscsc_ctrl.sv @@
// Phase sequencer of the card batch sorter.
module qscsc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic batch_end,
   input  qscsc_pkg::sts_type sts,
   output qscsc_pkg::cmd_type cmd,
   output logic idle
);
   import qscsc_pkg::*;
   op_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= OP_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         OP_IDLE: if (batch_end) state_in = OP_LOAD;
         OP_LOAD: begin
            state_in = OP_QSORT;
            cmd.start_q = 1'b1;
         end
         OP_QSORT: if (sts.done_q) begin
            state_in = OP_MSORT;
            cmd.start_m = 1'b1;
         end
         OP_MSORT: if (sts.done_m) begin
            state_in = OP_CMP;
            cmd.start_c = 1'b1;
         end
         OP_CMP: if (sts.done_c) begin
            state_in = OP_EMIT;
            cmd.start_e = 1'b1;
         end
         OP_EMIT: if (sts.done_e) state_in = OP_IDLE;
         default: state_in = OP_IDLE;
      endcase
   end
   assign idle = (state_ff == OP_IDLE);
endmodule

@@ rtl/core/qscsc_dp.sv @@
// Datapath of the card batch sorter: stores, sort sequencers and output register.
module qscsc_dp (
   input  logic clock,
   input  logic reset,
   input  logic idle,
   input  logic req_valid,
   output logic req_ready,
   input  qscsc_pkg::req_type req_data,
   output logic batch_end,
   input  qscsc_pkg::cmd_type cmd,
   output qscsc_pkg::sts_type sts,
   output logic rsp_valid,
   input  logic rsp_ready,
   output qscsc_pkg::rsp_type rsp_data
);
   import qscsc_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001, S_POP = 12'b0000_0000_0010,
      S_PIV = 12'b0000_0000_0100, S_RDJ = 12'b0000_0000_1000,
      S_CMPJ = 12'b0000_0001_0000, S_SWA = 12'b0000_0010_0000,
      S_SWB = 12'b0000_0100_0000, S_FIN = 12'b0000_1000_0000,
      S_FINB = 12'b0001_0000_0000, S_FINC = 12'b0010_0000_0000,
      S_PUSH = 12'b0100_0000_0000, S_PUSH2 = 12'b1000_0000_0000
   } qs_type;

   typedef enum logic [4:0] {
      M_IDLE = 5'b00001, M_RD = 5'b00010, M_SEL = 5'b00100,
      M_CPRD = 5'b01000, M_CPWR = 5'b10000
   } ms_type;

   card_type qmem [CAPACITY];
   card_type mmem [CAPACITY];
   card_type tmem [CAPACITY];
   logic [2*IDX_W-1:0] stk [CAPACITY];

   logic [CNT_W-1:0] count_ff;
   logic ovf_ff;
   logic acc;

   assign req_ready = idle;
   assign acc = req_valid && req_ready;
   assign batch_end = acc && req_data.last;

   // quicksort
   qs_type qs_ff;
   logic [CNT_W-1:0] depth_ff;
   logic [IDX_W-1:0] lo_ff, hi_ff, place_ff, j_ff;
   logic [29:0] piv_ff;
   card_type qa_ff, qb_ff, qrd_ff;
   // merge
   ms_type ms_ff;
   logic [CNT_W:0] width_ff, mlo_ff, mid_ff, mhi_ff, i_ff, jj_ff, k_ff;
   card_type li_ff, rj_ff;
   // compare and emit
   logic cmp_act_ff, emit_act_ff, stable_ff;
   logic [CNT_W-1:0] ck_ff;
   card_type cq_ff, cm_ff;
   logic cphase_ff;
   rsp_type out_ff;
   logic ovalid_ff, fetch_ff;

   logic done_q, done_m, done_c, done_e;
   assign sts = '{done_q: done_q, done_m: done_m, done_c: done_c, done_e: done_e};

   logic [CNT_W:0] nx, mhi_c;
   assign nx = {1'b0, count_ff};

   always_ff @(posedge clock) begin
      done_q <= 1'b0;
      done_m <= 1'b0;
      done_c <= 1'b0;
      done_e <= 1'b0;
      if (acc && count_ff < CNT_W'(CAPACITY)) begin
         qmem[count_ff[IDX_W-1:0]] <= '{suit: req_data.suit, key: req_data.card_value};
         mmem[count_ff[IDX_W-1:0]] <= '{suit: req_data.suit, key: req_data.card_value};
      end
      // quicksort sequencer
      unique case (qs_ff)
         S_IDLE: if (cmd.start_q) begin
            if (count_ff < CNT_W'(2)) done_q <= 1'b1;
            else begin
               stk[0] <= {IDX_W'(0), IDX_W'(count_ff - CNT_W'(1))};
               depth_ff <= CNT_W'(1);
               qs_ff <= S_POP;
            end
         end
         S_POP: begin
            if (depth_ff == '0) begin
               done_q <= 1'b1;
               qs_ff <= S_IDLE;
            end else begin
               {lo_ff, hi_ff} <= stk[IDX_W'(depth_ff - CNT_W'(1))];
               depth_ff <= depth_ff - CNT_W'(1);
               qs_ff <= S_PIV;
            end
         end
         S_PIV: begin
            qrd_ff <= qmem[hi_ff];
            place_ff <= lo_ff;
            j_ff <= lo_ff;
            qs_ff <= S_RDJ;
         end
         S_RDJ: begin
            piv_ff <= qrd_ff.key;
            if (j_ff == hi_ff) qs_ff <= S_FIN;
            else begin
               qrd_ff <= qmem[j_ff];
               qs_ff <= S_CMPJ;
            end
         end
         S_CMPJ: begin
            if (qrd_ff.key <= piv_ff) begin
               qa_ff <= qmem[place_ff];
               qb_ff <= qrd_ff;
               qs_ff <= S_SWA;
            end else begin
               j_ff <= j_ff + IDX_W'(1);
               qrd_ff.key <= piv_ff;
               qs_ff <= S_RDJ;
            end
         end
         S_SWA: begin
            qmem[place_ff] <= qb_ff;
            qs_ff <= S_SWB;
         end
         S_SWB: begin
            qmem[j_ff] <= qa_ff;
            place_ff <= place_ff + IDX_W'(1);
            j_ff <= j_ff + IDX_W'(1);
            qrd_ff.key <= piv_ff;
            qs_ff <= S_RDJ;
         end
         S_FIN: begin
            qa_ff <= qmem[place_ff];
            qb_ff <= qmem[hi_ff];
            qs_ff <= S_FINB;
         end
         S_FINB: begin
            qmem[place_ff] <= qb_ff;
            qs_ff <= S_FINC;
         end
         S_FINC: begin
            qmem[hi_ff] <= qa_ff;
            qs_ff <= S_PUSH;
         end
         S_PUSH: begin
            if ({1'b0, place_ff} + 7'd1 < {1'b0, hi_ff}
                && depth_ff < CNT_W'(CAPACITY)) begin
               stk[depth_ff[IDX_W-1:0]] <= {place_ff + IDX_W'(1), hi_ff};
               depth_ff <= depth_ff + CNT_W'(1);
            end
            qs_ff <= S_PUSH2;
         end
         S_PUSH2: begin
            if ({1'b0, place_ff} > {1'b0, lo_ff} + 7'd1
                && depth_ff < CNT_W'(CAPACITY)) begin
               stk[depth_ff[IDX_W-1:0]] <= {lo_ff, place_ff - IDX_W'(1)};
               depth_ff <= depth_ff + CNT_W'(1);
            end
            qs_ff <= S_POP;
         end
         default: qs_ff <= S_IDLE;
      endcase
      // merge sort sequencer
      unique case (ms_ff)
         M_IDLE: if (cmd.start_m) begin
            width_ff <= (CNT_W+1)'(1);
            mlo_ff <= '0;
            ms_ff <= M_RD;
            if (nx < (CNT_W+1)'(2)) begin
               done_m <= 1'b1;
               ms_ff <= M_IDLE;
            end
         end
         M_RD: begin
            if (width_ff >= nx) begin
               done_m <= 1'b1;
               ms_ff <= M_IDLE;
            end else if (mlo_ff + width_ff >= nx) begin
               width_ff <= width_ff << 1;
               mlo_ff <= '0;
            end else begin
               mid_ff <= mlo_ff + width_ff;
               mhi_ff <= mhi_c;
               i_ff <= mlo_ff;
               jj_ff <= mlo_ff + width_ff;
               k_ff <= mlo_ff;
               li_ff <= mmem[mlo_ff[IDX_W-1:0]];
               rj_ff <= mmem[IDX_W'(mlo_ff + width_ff)];
               ms_ff <= M_SEL;
            end
         end
         M_SEL: begin
            if (k_ff == mhi_ff) begin
               k_ff <= mlo_ff;
               ms_ff <= M_CPRD;
            end else begin
               if (jj_ff >= mhi_ff || (i_ff < mid_ff && li_ff.key <= rj_ff.key)) begin
                  tmem[k_ff[IDX_W-1:0]] <= li_ff;
                  li_ff <= mmem[IDX_W'(i_ff + (CNT_W+1)'(1))];
                  i_ff <= i_ff + (CNT_W+1)'(1);
               end else begin
                  tmem[k_ff[IDX_W-1:0]] <= rj_ff;
                  rj_ff <= mmem[IDX_W'(jj_ff + (CNT_W+1)'(1))];
                  jj_ff <= jj_ff + (CNT_W+1)'(1);
               end
               k_ff <= k_ff + (CNT_W+1)'(1);
            end
         end
         M_CPRD: begin
            if (k_ff == mhi_ff) begin
               mlo_ff <= mhi_ff;
               ms_ff <= M_RD;
            end else begin
               li_ff <= tmem[k_ff[IDX_W-1:0]];
               ms_ff <= M_CPWR;
            end
         end
         M_CPWR: begin
            mmem[k_ff[IDX_W-1:0]] <= li_ff;
            k_ff <= k_ff + (CNT_W+1)'(1);
            ms_ff <= M_CPRD;
         end
         default: ms_ff <= M_IDLE;
      endcase
      // suit comparison
      if (cmd.start_c) begin
         cmp_act_ff <= 1'b1;
         stable_ff <= 1'b1;
         ck_ff <= '0;
         cphase_ff <= 1'b0;
      end else if (cmp_act_ff) begin
         if (!cphase_ff) begin
            if (ck_ff == count_ff) begin
               cmp_act_ff <= 1'b0;
               done_c <= 1'b1;
            end else begin
               cq_ff <= qmem[ck_ff[IDX_W-1:0]];
               cm_ff <= mmem[ck_ff[IDX_W-1:0]];
               cphase_ff <= 1'b1;
            end
         end else begin
            if (cq_ff.suit != cm_ff.suit) stable_ff <= 1'b0;
            ck_ff <= ck_ff + CNT_W'(1);
            cphase_ff <= 1'b0;
         end
      end
      // emission
      if (cmd.start_e) begin
         emit_act_ff <= 1'b1;
         ck_ff <= '0;
         fetch_ff <= 1'b0;
      end else if (emit_act_ff) begin
         if (!ovalid_ff && !fetch_ff) begin
            cq_ff <= qmem[ck_ff[IDX_W-1:0]];
            fetch_ff <= 1'b1;
         end else if (fetch_ff) begin
            out_ff <= '{out_suit: cq_ff.suit, out_value: cq_ff.key,
                        is_stable: stable_ff, overflowed: ovf_ff,
                        end_of_batch: (ck_ff + CNT_W'(1) == count_ff)};
            ovalid_ff <= 1'b1;
            fetch_ff <= 1'b0;
         end else if (rsp_ready) begin
            ovalid_ff <= 1'b0;
            ck_ff <= ck_ff + CNT_W'(1);
            if (ck_ff + CNT_W'(1) == count_ff) begin
               emit_act_ff <= 1'b0;
               done_e <= 1'b1;
            end
         end
      end
      if (acc) begin
         if (count_ff < CNT_W'(CAPACITY)) count_ff <= count_ff + CNT_W'(1);
         else ovf_ff <= 1'b1;
      end
      if (done_e) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end
      if (reset) begin
         qs_ff <= S_IDLE;
         ms_ff <= M_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         cmp_act_ff <= 1'b0;
         emit_act_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         fetch_ff <= 1'b0;
         done_q <= 1'b0;
         done_m <= 1'b0;
         done_c <= 1'b0;
         done_e <= 1'b0;
      end
   end

   always_comb begin
      mhi_c = mlo_ff + (width_ff << 1);
      if (mhi_c > nx) mhi_c = nx;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_data = out_ff;
endmodule

@@ rtl/core/quick_sort_cards_stability_check.sv @@
// Top level of the card batch sorter with stability check.
// Cards are taken one per cycle while the block is idle; the request marked last
// starts the batch work and requests are refused until the sorted batch has been
// emitted. Quicksort swaps cards through a single store port, merge sort makes
// about log2(N) passes over the batch, and the suit compare and emission then
// step through the cards one at a time.
module quick_sort_cards_stability_check (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  qscsc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output qscsc_pkg::rsp_type rsp_data
);
   import qscsc_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic idle, batch_end;

   qscsc_ctrl u_ctrl (.clock(clock), .reset(reset), .batch_end(batch_end),
      .sts(sts), .cmd(cmd), .idle(idle));

   qscsc_dp u_dp (.clock(clock), .reset(reset), .idle(idle),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .batch_end(batch_end), .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(rsp_data));
endmodule

@@ test/qscsc_checker.sv @@
// Checker that predicts the sorted card batches and compares every response.
`timescale 1ns / 1ps
module qscsc_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  qscsc_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  qscsc_pkg::rsp_type rsp_data,
   output int fail_count,
   output int pending_count,
   output int batch_count,
   output int unstable_count,
   output int overflow_count
);
   import qscsc_pkg::*;

   card_type quick_cards [CAPACITY];
   card_type merge_cards [CAPACITY];
   card_type merge_work [CAPACITY];
   int held_cards;
   bit dropped;
   rsp_type sorted_queue [$];

   function automatic int partition_range(int lo, int hi);
      logic [29:0] pivot;
      int place;
      card_type t;
      pivot = quick_cards[hi].key;
      place = lo;
      for (int j = lo; j < hi; j++) begin
         if (quick_cards[j].key <= pivot) begin
            t = quick_cards[place];
            quick_cards[place] = quick_cards[j];
            quick_cards[j] = t;
            place++;
         end
      end
      t = quick_cards[place];
      quick_cards[place] = quick_cards[hi];
      quick_cards[hi] = t;
      return place;
   endfunction

   function automatic void quick_sort_cards(int n);
      int lo_stack [CAPACITY];
      int hi_stack [CAPACITY];
      int depth;
      int lo;
      int hi;
      int q;
      depth = 0;
      if (n < 2) return;
      lo_stack[0] = 0;
      hi_stack[0] = n - 1;
      depth = 1;
      while (depth > 0) begin
         depth--;
         lo = lo_stack[depth];
         hi = hi_stack[depth];
         q = partition_range(lo, hi);
         if (q + 1 < hi && depth < CAPACITY) begin
            lo_stack[depth] = q + 1;
            hi_stack[depth] = hi;
            depth++;
         end
         if (q > lo + 1 && depth < CAPACITY) begin
            lo_stack[depth] = lo;
            hi_stack[depth] = q - 1;
            depth++;
         end
      end
   endfunction

   function automatic void merge_sort_cards(int n);
      int i;
      int j;
      int k;
      int mid;
      int hi;
      bit take_left;
      for (int width = 1; width < n; width *= 2) begin
         for (int lo = 0; lo + width < n; lo += 2 * width) begin
            mid = lo + width;
            hi = (mid + width > n) ? n : mid + width;
            i = lo;
            j = mid;
            for (k = lo; k < hi; k++) begin
               if (i >= mid) take_left = 0;
               else if (j >= hi) take_left = 1;
               else take_left = merge_cards[i].key <= merge_cards[j].key;
               if (take_left) merge_work[k] = merge_cards[i++];
               else merge_work[k] = merge_cards[j++];
            end
            for (k = lo; k < hi; k++) merge_cards[k] = merge_work[k];
         end
      end
   endfunction

   task automatic take_request(req_type r);
      bit stable;
      rsp_type e;
      if (held_cards < CAPACITY) begin
         quick_cards[held_cards] = '{suit: r.suit, key: r.card_value};
         merge_cards[held_cards] = '{suit: r.suit, key: r.card_value};
         held_cards++;
      end else begin
         dropped = 1;
      end
      if (!r.last) return;
      quick_sort_cards(held_cards);
      merge_sort_cards(held_cards);
      stable = 1;
      for (int k = 0; k < held_cards; k++)
         if (quick_cards[k].suit != merge_cards[k].suit) stable = 0;
      for (int k = 0; k < held_cards; k++) begin
         e.out_suit = quick_cards[k].suit;
         e.out_value = quick_cards[k].key;
         e.is_stable = stable;
         e.overflowed = dropped;
         e.end_of_batch = (k + 1 == held_cards);
         sorted_queue.push_back(e);
      end
      batch_count++;
      if (!stable) unstable_count++;
      if (dropped) overflow_count++;
      held_cards = 0;
      dropped = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_cards = 0;
         dropped = 0;
         sorted_queue.delete();
         fail_count <= 0;
         batch_count = 0;
         unstable_count = 0;
         overflow_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sorted_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               if (sorted_queue[0] !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %h actual %h", sorted_queue[0], rsp_data);
                  fail_count <= fail_count + 1;
               end
               void'(sorted_queue.pop_front());
            end
         end
         if (req_valid && req_ready) take_request(req_data);
      end
      pending_count = sorted_queue.size();
   end
endmodule

@@ test/tb_quick_sort_cards_stability_check.sv @@
// Testbench top: drives card batches and handshake gaps, then gives the verdict.
`timescale 1ns / 1ps
module tb_quick_sort_cards_stability_check;
   import qscsc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   int fail_count;
   int pending_count;
   int batch_count;
   int unstable_count;
   int overflow_count;
   int cycle_count = 0;
   int sent_count = 0;

   localparam int CYCLE_LIMIT = 2000000;

   quick_sort_cards_stability_check u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   qscsc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .batch_count(batch_count), .unstable_count(unstable_count),
      .overflow_count(overflow_count)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("quick_sort_cards_stability_check verification failed");
         $finish;
      end
   end

   initial begin : rsp_side
      int g;
      @(posedge clock);
      while (1) begin
         g = gap_length();
         rsp_ready <= 0;
         repeat (g) @(posedge clock);
         rsp_ready <= 1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_card(logic [7:0] s, logic [29:0] v, logic l);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{suit: s, card_value: v, last: l};
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   task automatic send_batch(int n, int key_span);
      logic [29:0] v;
      for (int k = 0; k < n; k++) begin
         if (key_span == 0) v = 30'($urandom);
         else v = 30'($urandom_range(0, key_span));
         send_card(8'($urandom), v, k == n - 1);
      end
   endtask

   initial begin : req_side
      int n;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_card(8'h00, 30'h0, 1);
      send_card(8'hff, 30'h3fffffff, 0);
      send_card(8'h00, 30'h0, 1);
      send_card(8'haa, 30'h5, 0);
      send_card(8'h55, 30'h5, 0);
      send_card(8'h0f, 30'h5, 1);
      send_card(8'h01, 30'h3fffffff, 0);
      send_card(8'h02, 30'h2aaaaaaa, 0);
      send_card(8'h03, 30'h15555555, 0);
      send_card(8'h04, 30'h1, 1);
      send_card(8'hc3, 30'h7, 0);
      send_card(8'h3c, 30'h3, 0);
      send_card(8'h81, 30'h7, 0);
      send_card(8'h7e, 30'h3, 1);
      for (int k = 0; k < 66; k++) send_card(k[7:0], 30'(66 - k), k == 65);
      while (sent_count < 170) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
         case ($urandom_range(0, 2))
            0: send_batch(n, 0);
            1: send_batch(n, 3);
            default: send_batch(n, 1000);
         endcase
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d cards in %0d batches", sent_count, batch_count);
      $display("%0d batches unstable, %0d overflowed", unstable_count, overflow_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("quick_sort_cards_stability_check verification clean");
      end else begin
         $display("quick_sort_cards_stability_check verification failed");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/qscsc_pkg.sv
rtl/core/qscsc_ctrl.sv
rtl/core/qscsc_dp.sv
rtl/core/quick_sort_cards_stability_check.sv
test/qscsc_checker.sv
test/tb_quick_sort_cards_stability_check.sv
